/* rtl/cpq_pkg.sv */
`default_nettype none
package cpq_pkg;

    localparam int DEF_TABLE_SIZE   = 256;
    localparam int CORDIC_STEPS     = 22;
    localparam int ANGLE_W          = 24;
    localparam int PHASE_STEP_W     = 24;
    localparam int DIV_BITS         = 26;
    localparam int PHASE_W          = 8;
    localparam logic [ANGLE_W-1:0] HALF_TURN = 24'd8388608;
    localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RESET = 24'd65536;

    localparam logic [1:0] MODE_CONVERT  = 2'd0;
    localparam logic [1:0] MODE_LOAD_MAG = 2'd1;
    localparam logic [1:0] MODE_LOAD_DIR = 2'd2;

    // Arctangent of 2^-i in Q0.24 turns.
    function automatic logic [ANGLE_W-1:0] atan_turns(input logic [4:0] i);
        logic [ANGLE_W-1:0] r;
        case (i)
            5'd0:    r = 24'd2097152;
            5'd1:    r = 24'd1238021;
            5'd2:    r = 24'd654136;
            5'd3:    r = 24'd332050;
            5'd4:    r = 24'd166669;
            5'd5:    r = 24'd83416;
            5'd6:    r = 24'd41718;
            5'd7:    r = 24'd20860;
            5'd8:    r = 24'd10430;
            5'd9:    r = 24'd5215;
            5'd10:   r = 24'd2608;
            5'd11:   r = 24'd1304;
            5'd12:   r = 24'd652;
            5'd13:   r = 24'd326;
            5'd14:   r = 24'd163;
            5'd15:   r = 24'd81;
            5'd16:   r = 24'd41;
            5'd17:   r = 24'd20;
            5'd18:   r = 24'd10;
            5'd19:   r = 24'd5;
            5'd20:   r = 24'd3;
            5'd21:   r = 24'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/complex_to_amp_phase_quantizer_top.sv */
`default_nettype none
// Complex sample to amplitude and phase index quantizer.
// The input channel (s_valid/s_ready) carries one beat per item: a mode, a table
// index and the sample or table entry fields. Mode 1 loads a magnitude table
// entry, mode 2 loads a phase direction entry, and mode 0 converts a sample.
// Every beat yields exactly one result beat on the output channel
// (m_valid/m_ready); loads and unused modes are acknowledged with all zeros.
// A conversion runs 22 CORDIC iterations for the angle, a division by the phase
// step at two quotient bits per cycle, a direction read and a projection (a
// multiply, then an add), then a binary search through the magnitude memory,
// each probe a read and a compare, and a final two-entry comparison. One item is
// in flight at a time; s_ready is high only while the sequencer is idle.
// The result waits in an output register, so a stalled receiver does not stop
// the sequencer from going idle once that register has been freed; while it is
// still full, a finished item waits in its last state.
// Reset clears the sequencer, the output valid and sets phase_step to 65536.
// The tables are not cleared; entries must be loaded before they are used.
// Users write phase_step (cfg_wr_en/cfg_wr_data) only when idle; not enforced.
module complex_to_amp_phase_quantizer_top
    import cpq_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [23:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_mode,
    input  wire logic [7:0]         s_entry_index,
    input  wire logic signed [31:0] s_real_part,
    input  wire logic signed [31:0] s_imag_part,
    input  wire logic [31:0]        s_magnitude_value,
    input  wire logic signed [17:0] s_direction_cos,
    input  wire logic signed [17:0] s_direction_sin,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_amplitude_index,
    output logic [7:0]              m_phase_index,
    output logic                    m_is_conversion
);

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam logic [31:0] TS32 = 32'(TABLE_SIZE);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_ROT      = 11'b00000000010,
        ST_DIV      = 11'b00000000100,
        ST_DIR      = 11'b00000001000,
        ST_MULT     = 11'b00000010000,
        ST_ADD      = 11'b00000100000,
        ST_SRCH_RD  = 11'b00001000000,
        ST_SRCH_CMP = 11'b00010000000,
        ST_NEAR_RD  = 11'b00100000000,
        ST_NEAR_CMP = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [23:0] phase_step_reg;

    // Table memories.
    logic [31:0] mag_mem [TABLE_SIZE];
    logic [35:0] dir_mem [TABLE_SIZE];
    logic [31:0] mag_rd_a, mag_rd_b;
    logic [35:0] dir_rd;
    logic [AW-1:0] mag_addr_a, mag_addr_b, dir_addr;

    // Working registers.
    logic signed [35:0] x_reg, y_reg;
    logic [ANGLE_W-1:0] z_reg;
    logic               zero_reg;
    logic [4:0]         iter_reg;
    logic signed [31:0] re_reg, im_reg;
    logic [DIV_BITS-1:0] num_reg, rem_reg;
    logic [24:0]        den_reg;
    logic [3:0]         div_cnt_reg;
    logic [PHASE_W-1:0] ph_reg;
    logic signed [49:0] pc_reg, ps_reg;
    logic signed [50:0] proj_reg;
    logic [CW-1:0]      first_reg, count_reg;
    logic [7:0]         res_amp_reg, res_ph_reg;
    logic               res_conv_reg;
    logic               m_valid_reg;
    logic [7:0]         m_amp_reg, m_ph_reg;
    logic               m_conv_reg;

    logic accept;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // Address helpers.
    logic [31:0] idx_ext, ph_ext, mid_ext, first_ext, firstm1_ext;
    logic [CW-1:0] step_w, mid_w;
    assign idx_ext     = {24'd0, s_entry_index};
    assign ph_ext      = {24'd0, ph_reg};
    assign step_w      = count_reg >> 1;
    assign mid_w       = first_reg + step_w;
    assign mid_ext     = 32'(mid_w);
    assign first_ext   = 32'(first_reg);
    assign firstm1_ext = first_ext - 32'd1;
    assign dir_addr    = ph_ext[AW-1:0];

    always_comb begin
        mag_addr_a = mid_ext[AW-1:0];
        mag_addr_b = first_ext[AW-1:0];
        if (state_reg == ST_NEAR_RD) begin
            mag_addr_a = firstm1_ext[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_mode == MODE_LOAD_MAG && idx_ext < TS32) begin
            mag_mem[idx_ext[AW-1:0]] <= s_magnitude_value;
        end
        if (accept && s_mode == MODE_LOAD_DIR && idx_ext < TS32) begin
            dir_mem[idx_ext[AW-1:0]] <= {s_direction_sin, s_direction_cos};
        end
        mag_rd_a <= mag_mem[mag_addr_a];
        mag_rd_b <= mag_mem[mag_addr_b];
        dir_rd   <= dir_mem[dir_addr];
    end

    // CORDIC iteration.
    logic signed [35:0] xs, ys;
    logic [ANGLE_W-1:0] atn;
    logic [ANGLE_W-1:0] z_rot;
    assign xs    = x_reg >>> iter_reg;
    assign ys    = y_reg >>> iter_reg;
    assign atn   = atan_turns(iter_reg);
    assign z_rot = (y_reg >= 0) ? z_reg + atn : z_reg - atn;

    // Two restoring division steps per cycle.
    logic [DIV_BITS-1:0] r1, r2;
    logic                q1, q2;
    always_comb begin
        logic [DIV_BITS-1:0] t;
        t  = {rem_reg[DIV_BITS-2:0], num_reg[DIV_BITS-1]};
        q1 = (t >= {1'b0, den_reg});
        r1 = q1 ? t - {1'b0, den_reg} : t;
        t  = {r1[DIV_BITS-2:0], num_reg[DIV_BITS-2]};
        q2 = (t >= {1'b0, den_reg});
        r2 = q2 ? t - {1'b0, den_reg} : t;
    end

    // Search comparisons.
    logic signed [51:0] proj_ext, mag_a_ext;
    logic               mag_less;
    logic signed [52:0] two_proj, pair_sum;
    assign proj_ext  = 52'(proj_reg);
    assign mag_a_ext = {4'd0, mag_rd_a, 16'd0};
    assign mag_less  = mag_a_ext < proj_ext;
    assign two_proj  = {proj_reg[50], proj_reg, 1'b0};
    assign pair_sum  = 53'({1'b0, mag_rd_a, 16'd0}) + 53'({1'b0, mag_rd_b, 16'd0});

    logic ph_ok;
    assign ph_ok = ph_ext < TS32;

    logic [23:0] step_eff;
    assign step_eff = (phase_step_reg == '0) ? 24'd1 : phase_step_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_mode == MODE_CONVERT) ? ST_ROT : ST_DONE;
                end
            end
            ST_ROT:      if (iter_reg == 5'(CORDIC_STEPS - 1)) state_next = ST_DIV;
            ST_DIV:      if (div_cnt_reg == 4'd0) state_next = ST_DIR;
            ST_DIR:      state_next = ST_MULT;
            ST_MULT:     state_next = ST_ADD;
            ST_ADD:      state_next = ST_SRCH_RD;
            ST_SRCH_RD:  state_next = (count_reg == '0) ? ST_NEAR_RD : ST_SRCH_CMP;
            ST_SRCH_CMP: state_next = ST_SRCH_RD;
            ST_NEAR_RD: begin
                if (first_reg == '0 || first_ext >= TS32) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_NEAR_CMP;
                end
            end
            ST_NEAR_CMP: state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_step_reg <= PHASE_STEP_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                phase_step_reg <= cfg_wr_data;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                iter_reg     <= '0;
                res_amp_reg  <= '0;
                res_ph_reg   <= '0;
                res_conv_reg <= 1'b0;
                re_reg       <= s_real_part;
                im_reg       <= s_imag_part;
                zero_reg     <= (s_real_part == 0) && (s_imag_part == 0);
                if (s_real_part < 0) begin
                    x_reg <= -36'(s_real_part);
                    y_reg <= -36'(s_imag_part);
                    z_reg <= HALF_TURN;
                end else begin
                    x_reg <= 36'(s_real_part);
                    y_reg <= 36'(s_imag_part);
                    z_reg <= '0;
                end
            end
            ST_ROT: begin
                iter_reg <= iter_reg + 5'd1;
                if (y_reg >= 0) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atn;
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atn;
                end
                if (iter_reg == 5'(CORDIC_STEPS - 1)) begin
                    // Numerator 2*angle + step, divisor 2*step; the angle includes
                    // the final iteration.
                    num_reg     <= {1'b0, (zero_reg ? 24'd0 : z_rot), 1'b0}
                                   + {2'b00, step_eff};
                    den_reg     <= {step_eff, 1'b0};
                    rem_reg     <= '0;
                    div_cnt_reg <= 4'(DIV_BITS / 2 - 1);
                end
            end
            ST_DIV: begin
                num_reg     <= {num_reg[DIV_BITS-3:0], 2'b00};
                rem_reg     <= r2;
                ph_reg      <= {ph_reg[PHASE_W-3:0], q1, q2};
                div_cnt_reg <= div_cnt_reg - 4'd1;
            end
            ST_MULT: begin
                if (ph_ok) begin
                    pc_reg <= $signed(dir_rd[17:0]) * re_reg;
                    ps_reg <= $signed(dir_rd[35:18]) * im_reg;
                end else begin
                    pc_reg <= '0;
                    ps_reg <= '0;
                end
            end
            ST_ADD: begin
                proj_reg  <= 51'(pc_reg) + 51'(ps_reg);
                first_reg <= '0;
                count_reg <= CW'(TABLE_SIZE);
            end
            ST_SRCH_CMP: begin
                if (mag_less) begin
                    first_reg <= mid_w + CW'(1);
                    count_reg <= count_reg - step_w - CW'(1);
                end else begin
                    count_reg <= step_w;
                end
            end
            ST_NEAR_RD: begin
                res_ph_reg   <= ph_reg;
                res_conv_reg <= 1'b1;
                if (first_reg == '0) begin
                    res_amp_reg <= '0;
                end else if (first_ext >= TS32) begin
                    res_amp_reg <= 8'(TABLE_SIZE - 1);
                end
            end
            ST_NEAR_CMP: begin
                // Ties go to the lower entry.
                res_amp_reg <= (two_proj <= pair_sum) ? firstm1_ext[7:0] : first_ext[7:0];
            end
            ST_DONE: begin
                if (out_free) begin
                    m_amp_reg  <= res_amp_reg;
                    m_ph_reg   <= res_ph_reg;
                    m_conv_reg <= res_conv_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_amplitude_index = m_amp_reg;
    assign m_phase_index     = m_ph_reg;
    assign m_is_conversion   = m_conv_reg;

endmodule
`default_nettype wire

/* sim/cpq_result_checker.sv */
`timescale 1ns / 1ps
module cpq_result_checker
    import cpq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [23:0]        cfg_wr_data,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [1:0]         s_mode,
    input  wire logic [7:0]         s_entry_index,
    input  wire logic signed [31:0] s_real_part,
    input  wire logic signed [31:0] s_imag_part,
    input  wire logic [31:0]        s_magnitude_value,
    input  wire logic signed [17:0] s_direction_cos,
    input  wire logic signed [17:0] s_direction_sin,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [7:0]         m_amplitude_index,
    input  wire logic [7:0]         m_phase_index,
    input  wire logic               m_is_conversion,
    output int                      fail_count,
    output int                      awaited,
    output int                      conversions_seen
);

    typedef struct packed {
        logic [7:0] amp;
        logic [7:0] ph;
        logic       conv;
    } quant_result_t;

    localparam longint ATAN_TAB [CORDIC_STEPS] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1
    };

    logic [31:0]        mag_tab [DEF_TABLE_SIZE];
    logic signed [17:0] cos_tab [DEF_TABLE_SIZE];
    logic signed [17:0] sin_tab [DEF_TABLE_SIZE];
    logic [23:0]        step_reg;
    quant_result_t      pending_results [$];

    // Vectoring CORDIC; the arithmetic shifts floor, as the block's do.
    function automatic logic [23:0] angle_turns(input longint x, input longint y);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = longint'(HALF_TURN);
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TAB[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TAB[i];
            end
        end
        return z[23:0];
    endfunction

    // Lower-bound search followed by a nearest-of-two pick, ties to the lower entry.
    function automatic logic [7:0] nearest_amp(input longint proj);
        int     first;
        int     count;
        int     half;
        int     mid;
        longint m_lo;
        longint m_hi;
        first = 0;
        count = DEF_TABLE_SIZE;
        while (count > 0) begin
            half = count / 2;
            mid  = first + half;
            m_lo = longint'(mag_tab[mid]);
            if ((m_lo <<< 16) < proj) begin
                first = mid + 1;
                count = count - half - 1;
            end else begin
                count = half;
            end
        end
        if (first == 0) return 8'd0;
        if (first >= DEF_TABLE_SIZE) return 8'(DEF_TABLE_SIZE - 1);
        m_lo = longint'(mag_tab[first-1]);
        m_hi = longint'(mag_tab[first]);
        return ((proj - (m_lo <<< 16)) <= ((m_hi <<< 16) - proj)) ? 8'(first - 1) : 8'(first);
    endfunction

    function automatic quant_result_t quantize(input longint re, input longint im);
        quant_result_t r;
        longint        st;
        longint        ang;
        longint        c;
        longint        s;
        st     = (step_reg == 0) ? 64'sd1 : longint'(step_reg);
        ang    = longint'(angle_turns(re, im));
        r.ph   = 8'((2 * ang + st) / (2 * st));
        c      = longint'(cos_tab[r.ph]);
        s      = longint'(sin_tab[r.ph]);
        r.amp  = nearest_amp(c * re + s * im);
        r.conv = 1'b1;
        return r;
    endfunction

    assign awaited = pending_results.size();

    always @(posedge aclk) begin
        quant_result_t exp_r;
        int            errs;
        errs = 0;
        if (!aresetn) begin
            step_reg         <= PHASE_STEP_RESET;
            pending_results.delete();
            fail_count       <= 0;
            conversions_seen <= 0;
        end else begin
            if (cfg_wr_en) step_reg <= cfg_wr_data;
            // Compare first: a result can never belong to a beat accepted at this edge.
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    errs++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (exp_r.conv) conversions_seen <= conversions_seen + 1;
                    if (m_amplitude_index !== exp_r.amp) begin
                        $error("amplitude_index expected %0d got %0d", exp_r.amp,
                               m_amplitude_index);
                        errs++;
                    end
                    if (m_phase_index !== exp_r.ph) begin
                        $error("phase_index expected %0d got %0d", exp_r.ph, m_phase_index);
                        errs++;
                    end
                    if (m_is_conversion !== exp_r.conv) begin
                        $error("is_conversion expected %0d got %0d", exp_r.conv,
                               m_is_conversion);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
            if (s_valid && s_ready) begin
                exp_r = '0;
                case (s_mode)
                    MODE_LOAD_MAG: mag_tab[s_entry_index] = s_magnitude_value;
                    MODE_LOAD_DIR: begin
                        cos_tab[s_entry_index] = s_direction_cos;
                        sin_tab[s_entry_index] = s_direction_sin;
                    end
                    MODE_CONVERT: exp_r = quantize(longint'(s_real_part),
                                                   longint'(s_imag_part));
                    default: ;
                endcase
                pending_results.push_back(exp_r);
            end
        end
    end

endmodule

/* sim/complex_to_amp_phase_quantizer_top_tb.sv */
`timescale 1ns / 1ps
module complex_to_amp_phase_quantizer_top_tb;
    import cpq_pkg::*;

    // The one mode that the block ignores apart from acknowledging it.
    localparam logic [1:0] MODE_NONE = 2'd3;
    // Cycles without any beat before the run is declared hung; this is ample next to
    // the long receiver hold-off (LONG_HOLD) and the time that a conversion takes.
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [23:0]        cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_mode = MODE_CONVERT;
    logic [7:0]         s_entry_index = '0;
    logic signed [31:0] s_real_part = '0;
    logic signed [31:0] s_imag_part = '0;
    logic [31:0]        s_magnitude_value = '0;
    logic signed [17:0] s_direction_cos = '0;
    logic signed [17:0] s_direction_sin = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_amplitude_index;
    logic [7:0]         m_phase_index;
    logic               m_is_conversion;

    int fail_count;
    int awaited;
    int conversions_seen;
    int beats_sent = 0;
    int beats_taken = 0;
    int quiet_cycles = 0;
    int configs_written = 0;
    bit burst_mode = 1'b0;

    always #2 aclk = ~aclk;

    complex_to_amp_phase_quantizer_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_entry_index(s_entry_index), .s_real_part(s_real_part),
        .s_imag_part(s_imag_part), .s_magnitude_value(s_magnitude_value),
        .s_direction_cos(s_direction_cos), .s_direction_sin(s_direction_sin),
        .m_valid(m_valid), .m_ready(m_ready), .m_amplitude_index(m_amplitude_index),
        .m_phase_index(m_phase_index), .m_is_conversion(m_is_conversion)
    );

    cpq_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_entry_index(s_entry_index), .s_real_part(s_real_part),
        .s_imag_part(s_imag_part), .s_magnitude_value(s_magnitude_value),
        .s_direction_cos(s_direction_cos), .s_direction_sin(s_direction_sin),
        .m_valid(m_valid), .m_ready(m_ready), .m_amplitude_index(m_amplitude_index),
        .m_phase_index(m_phase_index), .m_is_conversion(m_is_conversion),
        .fail_count(fail_count), .awaited(awaited), .conversions_seen(conversions_seen)
    );

    // Watchdog: any beat on either channel resets the count of quiet cycles.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one beat on the input channel, after a random gap unless a burst is
    // running, and returns at the edge where the block takes it. Valid is only
    // lowered when a gap follows, so it is never dropped and raised in one step.
    task automatic send_beat(input logic [1:0] md, input logic [7:0] idx,
                             input logic [31:0] re, input logic [31:0] im,
                             input logic [31:0] mag, input logic [17:0] c,
                             input logic [17:0] s);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_mode            <= md;
        s_entry_index     <= idx;
        s_real_part       <= re;
        s_imag_part       <= im;
        s_magnitude_value <= mag;
        s_direction_cos   <= c;
        s_direction_sin   <= s;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic convert(input logic [31:0] re, input logic [31:0] im);
        send_beat(MODE_CONVERT, 8'($urandom), re, im, $urandom, 18'($urandom),
                  18'($urandom));
    endtask

    // A direction component in the legal range of -1.0 to +1.0 in Q1.16.
    function automatic logic [17:0] rand_unit();
        return 18'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    // A magnitude that keeps the table roughly ascending around this entry.
    function automatic logic [31:0] ordered_mag(input logic [7:0] idx);
        return {idx, 24'($urandom)};
    endfunction

    // The phase step may only change once the block has drained; every beat
    // gives a result, so an empty expectation queue means the block is idle.
    task automatic write_step(input logic [23:0] value);
        s_valid <= 1'b0;
        while (awaited != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        configs_written++;
    endtask

    // A random beat: mostly conversions of samples spread over many magnitudes,
    // with table reloads (now and then out of order) and some ignored beats.
    task automatic random_beat();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            convert($signed($urandom) >>> $urandom_range(0, 31),
                    $signed($urandom) >>> $urandom_range(0, 31));
        end else if (pick < 82) begin
            logic [7:0] idx;
            idx = 8'($urandom);
            send_beat(MODE_LOAD_MAG, idx, $urandom, $urandom,
                      ($urandom_range(0, 3) == 0) ? $urandom : ordered_mag(idx),
                      18'($urandom), 18'($urandom));
        end else if (pick < 95) begin
            send_beat(MODE_LOAD_DIR, 8'($urandom), $urandom, $urandom, $urandom,
                      rand_unit(), rand_unit());
        end else begin
            send_beat(MODE_NONE, 8'($urandom), $urandom, $urandom, $urandom,
                      18'($urandom), 18'($urandom));
        end
    endtask

    // Receiver: a random stall before each beat, runs with no stall at all, and
    // one long hold-off so that the block fills up and drops s_ready.
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (beats_taken == 700) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            stall = ((beats_taken / 90) % 4 == 2) ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            beats_taken++;
        end
    end

    initial begin
        logic [23:0] steps [4];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill both tables before any conversion can read them. The magnitude
        // table starts ascending and covers the full value range at its ends.
        for (int i = 0; i < DEF_TABLE_SIZE; i++)
            send_beat(MODE_LOAD_MAG, 8'(i), $urandom, $urandom,
                      (i == 0) ? 32'd0 : (i == 255) ? 32'hFFFF_FFFF : ordered_mag(8'(i)),
                      18'($urandom), 18'($urandom));
        for (int i = 0; i < DEF_TABLE_SIZE; i++)
            send_beat(MODE_LOAD_DIR, 8'(i), $urandom, $urandom, $urandom,
                      (i == 0) ? 18'sd65536 : (i == 128) ? -18'sd65536 : rand_unit(),
                      (i == 64) ? 18'sd65536 : (i == 192) ? -18'sd65536 : rand_unit());

        // Directed samples: zero, the axes, the extremes of both parts, a
        // negative real part in each half-plane, and the ignored mode.
        convert(32'd0, 32'd0);
        convert(32'h7FFF_FFFF, 32'd0);
        convert(32'h8000_0000, 32'd0);
        convert(32'd0, 32'h7FFF_FFFF);
        convert(32'd0, 32'h8000_0000);
        convert(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        convert(32'h8000_0000, 32'h8000_0000);
        convert(32'h8000_0000, 32'h7FFF_FFFF);
        convert(32'h7FFF_FFFF, 32'h8000_0000);
        convert(-32'sd65536, 32'sd1);
        convert(-32'sd65536, -32'sd1);
        convert(32'sd1, -32'sd1);
        convert(32'sd65536, 32'sd65536);
        send_beat(MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  18'h3FFFF, 18'h3FFFF);

        // Random phases under the reset step, the smallest and largest steps,
        // a coarse step and a random one.
        steps[0] = 24'd1;
        steps[1] = 24'hFF_FFFF;
        steps[2] = 24'd4096;
        steps[3] = 24'($urandom_range(1, 24'hFF_FFFF));
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) write_step(steps[ph-1]);
            for (int n = 0; n < 150; n++) begin
                burst_mode = (n >= 110);
                random_beat();
            end
        end
        burst_mode = 1'b0;
        s_valid <= 1'b0;

        while (awaited != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Sent %0d beats, %0d of them conversions checked, over %0d phase steps.",
                 beats_sent, conversions_seen, configs_written + 1);
        $display("Both tables were loaded in full and reloaded at random during the run.");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
